// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the frame queue RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define BFQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Consequent holds in the cycle of the antecedent.
`define BFQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define BFQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/bfq_pkg.sv =====
// ---------------------------------------------------------------------------
// bfq_pkg
// Types and constants of the bounded frame queue.
// ---------------------------------------------------------------------------
`default_nettype none

package bfq_pkg;

    localparam int DEPTH       = 16;
    localparam int FRAME_BITS  = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CAP_W       = 5;
    localparam int KIND_W      = 3;
    localparam int OUT_FRAME_W = 32;
    localparam int CNT_OUT_W   = 5;
    localparam int DROP_W      = 32;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int CAP_RESET   = 16;

    localparam logic POLICY_REFUSE_NEW = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ       = 3'd0,
        KIND_TRY_DEQ   = 3'd1,
        KIND_DRAIN_DEQ = 3'd2,
        KIND_CLEAR     = 3'd3,
        KIND_SHUTDOWN  = 3'd4
    } t_kind;

    typedef enum logic {
        REG_CAPACITY    = 1'b0,
        REG_DROP_POLICY = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/bfq_cell.sv =====
// ---------------------------------------------------------------------------
// bfq_cell
// One slot of the queue row: loads a new frame or takes its right neighbor.
// ---------------------------------------------------------------------------
`default_nettype none

module bfq_cell
    import bfq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [FRAME_BITS-1:0] i_right,
    input  wire logic [FRAME_BITS-1:0] i_frame,
    output logic      [FRAME_BITS-1:0] o_data
);

    logic [FRAME_BITS-1:0] r_data;
    logic [FRAME_BITS-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_frame;
        end else if (i_ctl.shift) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/bounded_frame_queue_drop_policy.sv =====
// ---------------------------------------------------------------------------
// bounded_frame_queue_drop_policy
// Bounded FIFO of frame handles held in a row of shifting cells, oldest in
// cell 0, with capacity and overflow policy registers and a drop counter.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_stall    i_kind, i_frame_in
//   out      source     o_out_valid / i_out_stall  o_accepted .. o_drop_total
//   config   sink       APB psel/penable/pwrite    paddr, pwdata, prdata
//
// One operation per cycle unless stalled: the row shifts toward cell 0 on a
// pop, a new frame loads in the first free cell, all in the transfer cycle.
// The result is registered and appears the cycle after the input transfer.
// The input stalls only while a result waits under output stall.
// Reset is synchronous; it empties the queue and clears shutdown and drops.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bounded_frame_queue_drop_policy
    import bfq_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [KIND_W-1:0]      i_kind,
    input  wire logic [FRAME_BITS-1:0]  i_frame_in,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic                        o_accepted,
    output logic                        o_dropped,
    output logic                        o_frame_valid,
    output logic [OUT_FRAME_W-1:0]      o_frame_out,
    output logic [CNT_OUT_W-1:0]        o_occupancy,
    output logic                        o_is_empty,
    output logic                        o_is_shut,
    output logic [DROP_W-1:0]           o_drop_total,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    logic [CAP_W-1:0]   r_cap;
    logic               r_policy;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_shut;
    logic               n_shut;
    logic [DROP_W-1:0]  r_drop;
    logic [DROP_W-1:0]  n_drop;

    logic               r_out_valid;
    logic               r_out_accepted;
    logic               r_out_dropped;
    logic               r_out_frame_valid;
    logic [OUT_FRAME_W-1:0] r_out_frame;
    logic [CNT_OUT_W-1:0]   r_out_occ;
    logic               r_out_empty;
    logic               r_out_shut;
    logic [DROP_W-1:0]  r_out_drop;

    logic               w_in_xfer;
    logic               w_cfg_wr;
    t_reg_idx           w_reg;
    logic [CNT_W-1:0]   w_eff_cap;
    logic               w_push;
    logic               w_pop;
    logic               w_accepted;
    logic               w_dropped;
    logic [CNT_W-1:0]   w_push_pos;
    logic [IDX_W-1:0]   w_push_idx;
    logic [FRAME_BITS-1:0] w_head;
    logic [OUT_FRAME_W-1:0] w_frame_out;

    logic [FRAME_BITS-1:0] w_data [DEPTH];

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;
    assign w_reg    = t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (w_reg)
            REG_CAPACITY:    prdata = APB_DATA_W'(r_cap);
            REG_DROP_POLICY: prdata = APB_DATA_W'(r_policy);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_W'(CAP_RESET);
            r_policy <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_CAPACITY:    r_cap    <= pwdata[CAP_W-1:0];
                REG_DROP_POLICY: r_policy <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // Operation decode
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_in_xfer  = i_in_valid & ~o_in_stall;
    assign w_head     = w_data[0];

    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = CNT_W'(1);
        end else if (CNT_W'(r_cap) > CNT_W'(DEPTH)) begin
            w_eff_cap = CNT_W'(DEPTH);
        end else begin
            w_eff_cap = CNT_W'(r_cap);
        end
    end

    always_comb begin
        w_push     = 1'b0;
        w_pop      = 1'b0;
        w_accepted = 1'b0;
        w_dropped  = 1'b0;
        n_count    = r_count;
        n_shut     = r_shut;
        n_drop     = r_drop;
        if (w_in_xfer) begin
            unique case (t_kind'(i_kind))
                KIND_ENQ: begin
                    if (!r_shut) begin
                        if (r_count >= w_eff_cap) begin
                            n_drop    = r_drop + DROP_W'(1);
                            w_dropped = 1'b1;
                            if (r_policy != POLICY_REFUSE_NEW && r_count != '0) begin
                                w_pop      = 1'b1;
                                w_push     = 1'b1;
                                w_accepted = 1'b1;
                            end
                        end else begin
                            w_push     = 1'b1;
                            w_accepted = 1'b1;
                            n_count    = r_count + CNT_W'(1);
                        end
                    end
                end
                KIND_TRY_DEQ: begin
                    if (r_count != '0 && !r_shut) begin
                        w_pop   = 1'b1;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                KIND_DRAIN_DEQ: begin
                    if (r_count != '0) begin
                        w_pop   = 1'b1;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                KIND_CLEAR: begin
                    n_count = '0;
                end
                KIND_SHUTDOWN: begin
                    n_shut = 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign w_push_pos  = w_pop ? (r_count - CNT_W'(1)) : r_count;
    assign w_push_idx  = w_push_pos[IDX_W-1:0];
    assign w_frame_out = w_pop ? OUT_FRAME_W'(w_head) : '0;

    // Cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctl             w_ctl;
        logic [FRAME_BITS-1:0] w_right;

        assign w_ctl.shift = w_pop;
        assign w_ctl.load  = w_push && (w_push_idx == IDX_W'(g));

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_data[g+1];
        end

        bfq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_right (w_right),
            .i_frame (i_frame_in),
            .o_data  (w_data[g])
        );
    end

    // Queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_shut  <= 1'b0;
            r_drop  <= '0;
        end else begin
            r_count <= n_count;
            r_shut  <= n_shut;
            r_drop  <= n_drop;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_out_accepted    <= w_accepted;
            r_out_dropped     <= w_dropped;
            r_out_frame_valid <= w_pop && !w_push;
            r_out_frame       <= (w_pop && !w_push) ? w_frame_out : '0;
            r_out_occ         <= CNT_OUT_W'(n_count);
            r_out_empty       <= (n_count == '0);
            r_out_shut        <= n_shut;
            r_out_drop        <= n_drop;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_accepted    = r_out_accepted;
    assign o_dropped     = r_out_dropped;
    assign o_frame_valid = r_out_frame_valid;
    assign o_frame_out   = r_out_frame;
    assign o_occupancy   = r_out_occ;
    assign o_is_empty    = r_out_empty;
    assign o_is_shut     = r_out_shut;
    assign o_drop_total  = r_out_drop;

    `BFQ_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `BFQ_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_in_xfer, r_out_valid)
    `BFQ_ASSERT_IMPL(a_accept_not_shut, i_clk, i_rst_n, r_out_valid && r_out_accepted, !r_out_shut)
    `BFQ_ASSERT_IMPL(a_shut_sticky, i_clk, i_rst_n, $past(i_rst_n) && $past(r_shut), r_shut)

endmodule

`default_nettype wire

// ===== tb/sv/bounded_frame_queue_drop_policy_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_frame_queue_drop_policy_tb
// Self-checking bench for the bounded frame queue. A driver feeds operations
// from a pending list, a scoreboard model of the queue predicts each result,
// and a monitor compares every output transfer field by field. Capacity and
// overflow policy are reprogrammed over APB between phases, and the flow-control
// mix changes from phase to phase, including a long output hold-off and a
// drain pause on the input side.
// ----------------------------------------------------------------------------
module bounded_frame_queue_drop_policy_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfq_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int HOLD_CYCLES = 400;

    localparam logic [KIND_W-1:0]     KIND_RSVD_FIRST = 3'd5;
    localparam logic [KIND_W-1:0]     KIND_RSVD_LAST  = 3'd7;
    localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY   = APB_ADDR_W'(4 * int'(REG_CAPACITY));
    localparam logic [APB_ADDR_W-1:0] ADDR_POLICY     = APB_ADDR_W'(4 * int'(REG_DROP_POLICY));

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [FRAME_BITS-1:0] frame;
    } t_queue_op;

    typedef struct packed {
        logic                   accepted;
        logic                   dropped;
        logic                   frame_valid;
        logic [OUT_FRAME_W-1:0] frame_out;
        logic [CNT_OUT_W-1:0]   occupancy;
        logic                   is_empty;
        logic                   is_shut;
        logic [DROP_W-1:0]      drop_total;
    } t_queue_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [KIND_W-1:0]      i_kind = '0;
    logic [FRAME_BITS-1:0]  i_frame_in = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic                   o_accepted;
    logic                   o_dropped;
    logic                   o_frame_valid;
    logic [OUT_FRAME_W-1:0] o_frame_out;
    logic [CNT_OUT_W-1:0]   o_occupancy;
    logic                   o_is_empty;
    logic                   o_is_shut;
    logic [DROP_W-1:0]      o_drop_total;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    t_queue_op             pending_ops[$];
    t_queue_result         pending_results[$];

    // scoreboard copy of the queue and its registers
    logic [FRAME_BITS-1:0] held_frames[$];
    logic [CAP_W-1:0]      cap_reg = 5'(CAP_RESET);
    logic                  policy_reg = 1'b0;
    logic                  shut_seen = 1'b0;
    logic [DROP_W-1:0]     drop_count = '0;

    int errors = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_burst_req = 0;
    int stall_burst_ack = 0;
    int stall_burst_left = 0;
    int ops_sent = 0;
    int frames_out = 0;
    int drop_events = 0;
    int settings_used = 1;

    bounded_frame_queue_drop_policy u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_frame_in    (i_frame_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_accepted    (o_accepted),
        .o_dropped     (o_dropped),
        .o_frame_valid (o_frame_valid),
        .o_frame_out   (o_frame_out),
        .o_occupancy   (o_occupancy),
        .o_is_empty    (o_is_empty),
        .o_is_shut     (o_is_shut),
        .o_drop_total  (o_drop_total),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic t_queue_result queue_apply(input logic [KIND_W-1:0] kind,
                                                  input logic [FRAME_BITS-1:0] frame);
        t_queue_result res;
        int unsigned   limit;
        res = '0;
        limit = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : cap_reg);
        case (kind)
            KIND_ENQ: begin
                if (!shut_seen) begin
                    if (held_frames.size() >= limit) begin
                        drop_count = drop_count + 1;
                        res.dropped = 1'b1;
                        if (policy_reg != POLICY_REFUSE_NEW && held_frames.size() > 0) begin
                            void'(held_frames.pop_front());
                            held_frames.push_back(frame);
                            res.accepted = 1'b1;
                        end
                    end else begin
                        held_frames.push_back(frame);
                        res.accepted = 1'b1;
                    end
                end
            end
            KIND_TRY_DEQ, KIND_DRAIN_DEQ: begin
                if (held_frames.size() > 0 && (kind == KIND_DRAIN_DEQ || !shut_seen)) begin
                    res.frame_out = held_frames.pop_front();
                    res.frame_valid = 1'b1;
                end
            end
            KIND_CLEAR: held_frames.delete();
            KIND_SHUTDOWN: shut_seen = 1'b1;
            default: ;
        endcase
        res.occupancy = CNT_OUT_W'(held_frames.size());
        res.is_empty = (held_frames.size() == 0);
        res.is_shut = shut_seen;
        res.drop_total = drop_count;
        return res;
    endfunction

    // driver: hold the payload under stall, advance on transfer
    always @(posedge i_clk) begin : driver
        t_queue_op op;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                pending_results.push_back(queue_apply(i_kind, i_frame_in));
                ops_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    op = pending_ops.pop_front();
                    i_in_valid <= 1'b1;
                    i_kind <= op.kind;
                    i_frame_in <= op.frame;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_burst_left != 0) begin
            stall_burst_left <= stall_burst_left - 1;
        end else if (stall_burst_ack != stall_burst_req) begin
            stall_burst_left <= HOLD_CYCLES;
            stall_burst_ack <= stall_burst_req;
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, name, want, got);
        end
    endfunction

    // monitor: compare each output transfer with the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_queue_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t ns: result transfer with none expected, actual frame 0x%08h",
                             $time, o_frame_out);
                end else begin
                    want = pending_results.pop_front();
                    check_field("accepted", want.accepted, o_accepted);
                    check_field("dropped", want.dropped, o_dropped);
                    check_field("frame_valid", want.frame_valid, o_frame_valid);
                    check_field("frame_out", want.frame_out, o_frame_out);
                    check_field("occupancy", want.occupancy, o_occupancy);
                    check_field("is_empty", want.is_empty, o_is_empty);
                    check_field("is_shut", want.is_shut, o_is_shut);
                    check_field("drop_total", want.drop_total, o_drop_total);
                    if (want.frame_valid) frames_out++;
                    if (want.dropped) drop_events++;
                end
            end
            i_out_stall <= (stall_burst_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic reg_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_regs();
        logic [APB_DATA_W-1:0] rd;
        reg_read(ADDR_CAPACITY, rd);
        check_field("capacity readback", {27'd0, cap_reg}, rd);
        reg_read(ADDR_POLICY, rd);
        check_field("drop_policy readback", {31'd0, policy_reg}, rd);
    endtask

    task automatic set_config(input logic [CAP_W-1:0] cap, input logic policy);
        logic [APB_DATA_W-1:0] junk;
        junk = $urandom;
        reg_write(ADDR_CAPACITY, (junk & ~32'h1F) | APB_DATA_W'(cap));
        cap_reg = cap;
        junk = $urandom;
        reg_write(ADDR_POLICY, {junk[31:1], policy});
        policy_reg = policy;
        settings_used++;
        check_regs();
    endtask

    // sample between edges so the driver's updates of this cycle have settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_ops.size() != 0 || i_in_valid || pending_results.size() != 0);
    endtask

    task automatic add_op(input logic [KIND_W-1:0] kind, input logic [FRAME_BITS-1:0] frame);
        t_queue_op op;
        op.kind = kind;
        op.frame = frame;
        pending_ops.push_back(op);
    endtask

    task automatic add_random_ops(input int count, input int enq_pct, input bit allow_shut);
        int                r;
        int                s;
        logic [KIND_W-1:0] kind;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, 99);
            if (r < enq_pct) kind = KIND_ENQ;
            else if (s < 40) kind = KIND_TRY_DEQ;
            else if (s < 75) kind = KIND_DRAIN_DEQ;
            else if (s < 85) kind = KIND_CLEAR;
            else if (s < 93 || !allow_shut)
                kind = KIND_W'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
            else kind = KIND_SHUTDOWN;
            add_op(kind, $urandom);
        end
    endtask

    task automatic run_phase(input int count, input int enq_pct, input int idle_pct,
                             input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        add_random_ops(count, enq_pct, 1'b0);
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_regs();

        // fill to the reset capacity, overflow, dequeue both ways, odd kinds, empty queue
        add_op(KIND_ENQ, 32'h0000_0000);
        add_op(KIND_ENQ, 32'hFFFF_FFFF);
        add_op(KIND_ENQ, 32'h5555_5555);
        add_op(KIND_ENQ, 32'hAAAA_AAAA);
        add_op(KIND_ENQ, 32'h0000_0001);
        add_op(KIND_ENQ, 32'h8000_0000);
        for (int n = 0; n < 11; n++) add_op(KIND_ENQ, $urandom);
        add_op(KIND_TRY_DEQ, $urandom);
        add_op(KIND_DRAIN_DEQ, $urandom);
        add_op(KIND_RSVD_FIRST, $urandom);
        add_op(KIND_RSVD_LAST, $urandom);
        add_op(KIND_CLEAR, $urandom);
        add_op(KIND_TRY_DEQ, $urandom);
        add_op(KIND_DRAIN_DEQ, $urandom);
        wait_idle();

        set_config(5'd0, 1'b1);
        run_phase(150, 55, 0, 0);
        set_config(5'd31, 1'b0);
        run_phase(170, 60, 74, 0);

        // long output hold-off while the sender keeps offering
        set_config(5'd3, 1'b1);
        stall_burst_req++;
        run_phase(170, 55, 0, 74);

        // input pause until every result is back, then resume
        set_config(5'd16, 1'b1);
        send_idle_pct = 37;
        recv_stall_pct = 37;
        add_random_ops(90, 55, 1'b0);
        wait_idle();
        add_random_ops(90, 55, 1'b0);
        wait_idle();

        // capacity lowered below the current fill level
        set_config(5'd16, 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_op(KIND_CLEAR, $urandom);
        for (int n = 0; n < 14; n++) add_op(KIND_ENQ, $urandom);
        wait_idle();
        set_config(5'd4, 1'b1);
        run_phase(150, 55, 37, 37);
        set_config(5'd1, 1'b0);
        run_phase(150, 55, 74, 74);
        set_config(5'($urandom_range(0, 31)), 1'($urandom));
        run_phase(150, 50, 37, 0);

        // shutdown: enqueue refused, try-dequeue empty, drain still hands out
        set_config(5'd6, 1'b1);
        send_idle_pct = 0;
        recv_stall_pct = 37;
        add_random_ops(30, 80, 1'b0);
        add_op(KIND_SHUTDOWN, $urandom);
        add_op(KIND_ENQ, $urandom);
        add_op(KIND_TRY_DEQ, $urandom);
        add_op(KIND_DRAIN_DEQ, $urandom);
        add_op(KIND_DRAIN_DEQ, $urandom);
        add_random_ops(150, 40, 1'b1);
        wait_idle();

        repeat (8) @(posedge i_clk);
        $display("Ran %0d queue operations over %0d register settings, %0d frames dequeued,",
                 ops_sent, settings_used, frames_out);
        $display("%0d overflow drops, with back-pressure, input gaps and shutdown exercised.",
                 drop_events);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
